[hw/rtl/udc_pkg.sv]
// Shared types and constants for the UTF-8 decode and classify block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package udc_pkg;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 3;
  localparam int unsigned LenW      = 3;
  localparam int unsigned CpW       = 21;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 24;
  localparam int unsigned OutUserW  = 3;

  localparam logic [CountW-1:0] MaxCount = 3'd4;

  localparam logic [LenW-1:0] LenReject = 3'd0;
  localparam logic [LenW-1:0] LenOne    = 3'd1;
  localparam logic [LenW-1:0] LenTwo    = 3'd2;
  localparam logic [LenW-1:0] LenThree  = 3'd3;
  localparam logic [LenW-1:0] LenFour   = 3'd4;

  localparam logic [CpW-1:0] CpMax      = 21'h10FFFF;
  localparam logic [CpW-1:0] CpMin3     = 21'h000800;
  localparam logic [CpW-1:0] CpMin4     = 21'h010000;
  localparam logic [CpW-1:0] CpSurLo    = 21'h00D800;
  localparam logic [CpW-1:0] CpSurHi    = 21'h00DFFF;
  localparam logic [CpW-1:0] CpMin2     = 21'h000080;

  typedef struct packed {
    logic       is_nul;
    logic       is_ascii;
    logic       is_cont;
    logic       is_lead2;
    logic       is_lead3;
    logic       is_lead4;
    logic [6:0] bits;
  } lane_info_t;

  typedef struct packed {
    logic cjk;
    logic letter;
    logic joiner;
  } class_flags_t;

endpackage

[hw/rtl/utf8_decode_classify_top.sv]
// Top level of the strict UTF-8 decoder and classifier: stream ports, two pipeline stages.
// Depends on udc_pkg, udc_lane, udc_merge and udc_class.
// Each input transaction is registered in stage one (lane results), then in stage two (length, value, flags).
// Throughput: one transaction per cycle while the output is not stalled; four byte lanes feed one merge stage.
// Both stages advance when the next one is empty or being drained.
// Reset: asynchronous, active low; clears the stage valid flags only.
`timescale 1ns / 1ps

module utf8_decode_classify_top
  import udc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] byte_first, [15:8] byte_second, [23:16] byte_third,
  // [31:24] byte_fourth, [34:32] bytes_available, [39:35] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [2:0] seq_length, [23:3] code_point
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] cjk_flag, [1] letter_flag, [2] joiner_flag
  output logic [OutUserW-1:0] m_axis_tuser
);

  lane_info_t [NumLanes-1:0] lane_info;
  lane_info_t [NumLanes-1:0] lane_q;
  logic [CountW-1:0]         count_d;
  logic [CountW-1:0]         count_q;
  logic                      v1_q;
  logic                      v2_q;
  logic                      s1_en;
  logic                      s2_en;
  logic [LenW-1:0]           len_d;
  logic [LenW-1:0]           len_q;
  logic [CpW-1:0]            cp_d;
  logic [CpW-1:0]            cp_q;
  class_flags_t              flags_d;
  class_flags_t              flags_q;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    udc_lane u_lane (
      .byte_i (s_axis_tdata[g*ByteW +: ByteW]),
      .info_o (lane_info[g])
    );
  end

  assign count_d = (s_axis_tdata[34:32] > MaxCount) ? MaxCount : s_axis_tdata[34:32];

  assign s2_en         = !v2_q || m_axis_tready;
  assign s1_en         = !v1_q || s2_en;
  assign s_axis_tready = s1_en;

  udc_merge u_merge (
    .lane_i  (lane_q),
    .count_i (count_q),
    .len_o   (len_d),
    .cp_o    (cp_d)
  );

  udc_class u_class (
    .cp_i    (cp_d),
    .flags_o (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s1_en) v1_q <= s_axis_tvalid;
      if (s2_en) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && s_axis_tvalid) begin
      lane_q  <= lane_info;
      count_q <= count_d;
    end
    if (s2_en && v1_q) begin
      len_q   <= len_d;
      cp_q    <= cp_d;
      flags_q <= flags_d;
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {cp_q, len_q};
  assign m_axis_tuser  = {flags_q.joiner, flags_q.letter, flags_q.cjk};

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (len_q <= LenFour))
    else $error("result length out of range");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && len_q == LenReject) |-> (cp_q == '0 && m_axis_tuser == '0))
    else $error("rejected result carries a value or flags");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v2_q |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_joiner_not_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && flags_q.joiner) |-> !flags_q.letter)
    else $error("joiner classified as letter");

endmodule

[hw/rtl/udc_lane.sv]
// One byte lane: classifies a window byte as NUL, ASCII, continuation or lead; bytes F8 to FF set no class.
// Depends on udc_pkg.
`timescale 1ns / 1ps

module udc_lane
  import udc_pkg::*;
(
  input  logic [ByteW-1:0] byte_i,
  output lane_info_t       info_o
);

  always_comb begin
    info_o          = '0;
    info_o.bits     = byte_i[6:0];
    info_o.is_nul   = (byte_i == 8'h00);
    case (byte_i) inside
      [8'h00:8'h7F]: info_o.is_ascii = 1'b1;
      [8'h80:8'hBF]: info_o.is_cont  = 1'b1;
      [8'hC0:8'hDF]: info_o.is_lead2 = 1'b1;
      [8'hE0:8'hEF]: info_o.is_lead3 = 1'b1;
      [8'hF0:8'hF7]: info_o.is_lead4 = 1'b1;
      default:       info_o.bits     = byte_i[6:0];
    endcase
  end

endmodule

[hw/rtl/udc_merge.sv]
// Merge stage: combines the four lane results into a length and a scalar value,
// rejecting truncated, malformed, overlong, surrogate and out-of-range forms.
// Depends on udc_pkg.
`timescale 1ns / 1ps

module udc_merge
  import udc_pkg::*;
(
  input  lane_info_t [NumLanes-1:0] lane_i,
  input  logic [CountW-1:0]         count_i,
  output logic [LenW-1:0]           len_o,
  output logic [CpW-1:0]            cp_o
);

  logic [CpW-1:0] cp2;
  logic [CpW-1:0] cp3;
  logic [CpW-1:0] cp4;
  logic           ok2;
  logic           ok3;
  logic           ok4;

  always_comb begin
    cp2 = {10'd0, lane_i[0].bits[4:0], lane_i[1].bits[5:0]};
    cp3 = {5'd0, lane_i[0].bits[3:0], lane_i[1].bits[5:0], lane_i[2].bits[5:0]};
    cp4 = {lane_i[0].bits[2:0], lane_i[1].bits[5:0], lane_i[2].bits[5:0],
           lane_i[3].bits[5:0]};

    ok2 = (count_i >= LenTwo) && lane_i[1].is_cont && (cp2 >= CpMin2);
    ok3 = (count_i >= LenThree) && lane_i[1].is_cont && lane_i[2].is_cont &&
          (cp3 >= CpMin3) && !((cp3 >= CpSurLo) && (cp3 <= CpSurHi));
    ok4 = (count_i >= LenFour) && lane_i[1].is_cont && lane_i[2].is_cont &&
          lane_i[3].is_cont && (cp4 >= CpMin4) && (cp4 <= CpMax);

    len_o = LenReject;
    cp_o  = '0;
    if (count_i != '0 && !lane_i[0].is_nul) begin
      if (lane_i[0].is_ascii) begin
        len_o = LenOne;
        cp_o  = {14'd0, lane_i[0].bits};
      end else if (lane_i[0].is_lead2 && ok2) begin
        len_o = LenTwo;
        cp_o  = cp2;
      end else if (lane_i[0].is_lead3 && ok3) begin
        len_o = LenThree;
        cp_o  = cp3;
      end else if (lane_i[0].is_lead4 && ok4) begin
        len_o = LenFour;
        cp_o  = cp4;
      end
    end
  end

endmodule

[hw/rtl/udc_class.sv]
// Classifier: range compares on a scalar value for CJK and letter flags, equality compares for the joiner flag.
// Depends on udc_pkg.
`timescale 1ns / 1ps

module udc_class
  import udc_pkg::*;
(
  input  logic [CpW-1:0] cp_i,
  output class_flags_t   flags_o
);

  logic cjk;
  logic latin;

  always_comb begin
    cjk = 1'b0;
    case (cp_i) inside
      [21'h01100:21'h0115F], [21'h02E80:21'h0303E], [21'h03041:21'h033FF],
      [21'h03400:21'h04DBF], [21'h04E00:21'h09FFF], [21'h0A000:21'h0A4CF],
      [21'h0AC00:21'h0D7AF], [21'h0F900:21'h0FAFF], [21'h0FE30:21'h0FE4F],
      [21'h0FF00:21'h0FF60], [21'h20000:21'h3FFFD]: cjk = 1'b1;
      default: cjk = 1'b0;
    endcase

    latin = 1'b0;
    case (cp_i) inside
      [21'h041:21'h05A], [21'h061:21'h07A], [21'h0C0:21'h0D6],
      [21'h0D8:21'h0F6], [21'h0F8:21'h0FF], [21'h100:21'h24F],
      [21'h300:21'h4FF], [21'h1E00:21'h1EFF]: latin = 1'b1;
      default: latin = 1'b0;
    endcase

    flags_o.cjk    = cjk;
    flags_o.letter = cjk | latin;
    flags_o.joiner = (cp_i == 21'h27) || (cp_i == 21'h2D) || (cp_i == 21'h2019);
  end

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for utf8_decode_classify_top: decodes and classifies each window
// with a local predictor and checks every output transaction in order under random stalls.
// Depends on udc_pkg and utf8_decode_classify_top.
`timescale 1ns / 1ps

module testbench;
  import udc_pkg::*;

  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [CpW-1:0]  cp;
    class_flags_t    flags;
  } decoded_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  logic        hold_req = 1'b0;
  logic        no_idle  = 1'b0;
  int unsigned err_cnt  = 0;
  decoded_t    decoded_q [$];

  utf8_decode_classify_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic in_span(input logic [CpW-1:0] v, input int unsigned lo,
                                   input int unsigned hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic is_cjk(input logic [CpW-1:0] v);
    return in_span(v, 'h1100, 'h115F) || in_span(v, 'h2E80, 'h303E) ||
           in_span(v, 'h3041, 'h33FF) || in_span(v, 'h3400, 'h4DBF) ||
           in_span(v, 'h4E00, 'h9FFF) || in_span(v, 'hA000, 'hA4CF) ||
           in_span(v, 'hAC00, 'hD7AF) || in_span(v, 'hF900, 'hFAFF) ||
           in_span(v, 'hFE30, 'hFE4F) || in_span(v, 'hFF00, 'hFF60) ||
           in_span(v, 'h20000, 'h3FFFD);
  endfunction

  function automatic logic is_letter(input logic [CpW-1:0] v);
    return in_span(v, 'h41, 'h5A) || in_span(v, 'h61, 'h7A) ||
           in_span(v, 'hC0, 'hD6) || in_span(v, 'hD8, 'hF6) ||
           in_span(v, 'hF8, 'hFF) || in_span(v, 'h100, 'h24F) ||
           in_span(v, 'h1E00, 'h1EFF) || in_span(v, 'h300, 'h4FF) || is_cjk(v);
  endfunction

  function automatic decoded_t decode_window(input logic [3:0][7:0] win,
                                             input logic [CountW-1:0] cnt);
    decoded_t         r;
    logic [CountW-1:0] avail;
    logic [LenW-1:0]  len;
    logic [CpW-1:0]   v;
    logic             ok;
    avail = (cnt > MaxCount) ? MaxCount : cnt;
    len   = LenReject;
    v     = '0;
    ok    = 1'b1;
    if (avail == 0 || win[0] == 8'h00) begin
      ok = 1'b0;
    end else if (win[0][7] == 1'b0) begin
      len = LenOne;
      v   = CpW'(win[0]);
    end else if (win[0][7:5] == 3'b110) begin
      len = LenTwo;
      v   = CpW'(win[0][4:0]);
    end else if (win[0][7:4] == 4'b1110) begin
      len = LenThree;
      v   = CpW'(win[0][3:0]);
    end else if (win[0][7:3] == 5'b11110) begin
      len = LenFour;
      v   = CpW'(win[0][2:0]);
    end else begin
      ok = 1'b0;
    end
    if (ok && len > avail) ok = 1'b0;
    for (int i = 1; i < NumLanes; i++) begin
      if (ok && i < len) begin
        if (win[i][7:6] != 2'b10) ok = 1'b0;
        v = {v[CpW-7:0], win[i][5:0]};
      end
    end
    if (ok) begin
      case (len)
        LenTwo:   if (v < CpMin2) ok = 1'b0;
        LenThree: if (v < CpMin3) ok = 1'b0;
        LenFour:  if (v < CpMin4) ok = 1'b0;
        default: ;
      endcase
    end
    if (ok && (v > CpMax || (v >= CpSurLo && v <= CpSurHi))) ok = 1'b0;
    if (!ok) begin
      len = LenReject;
      v   = '0;
    end
    r.len          = len;
    r.cp           = v;
    r.flags.cjk    = is_cjk(v);
    r.flags.letter = is_letter(v);
    r.flags.joiner = (v == 'h27) || (v == 'h2D) || (v == 'h2019);
    return r;
  endfunction

  function automatic logic [LenW-1:0] natural_len(input logic [CpW-1:0] cp);
    if (cp < CpMin2) return LenOne;
    if (cp < CpMin3) return LenTwo;
    if (cp < CpMin4) return LenThree;
    return LenFour;
  endfunction

  // Encode cp in n bytes; lanes past the sequence carry random bytes.
  function automatic logic [3:0][7:0] encode_len(input logic [CpW-1:0] cp,
                                                 input logic [LenW-1:0] n);
    logic [3:0][7:0] w;
    w = $urandom;
    case (n)
      LenOne: w[0] = {1'b0, cp[6:0]};
      LenTwo: begin
        w[0] = {3'b110, cp[10:6]};
        w[1] = {2'b10, cp[5:0]};
      end
      LenThree: begin
        w[0] = {4'b1110, cp[15:12]};
        w[1] = {2'b10, cp[11:6]};
        w[2] = {2'b10, cp[5:0]};
      end
      default: begin
        w[0] = {5'b11110, cp[20:18]};
        w[1] = {2'b10, cp[17:12]};
        w[2] = {2'b10, cp[11:6]};
        w[3] = {2'b10, cp[5:0]};
      end
    endcase
    return w;
  endfunction

  function automatic int unsigned class_edge(input int unsigned k);
    case (k)
      0: return 'h41;     1: return 'h5A;     2: return 'h61;     3: return 'h7A;
      4: return 'hC0;     5: return 'hD6;     6: return 'hD8;     7: return 'hF6;
      8: return 'hF8;     9: return 'hFF;     10: return 'h100;   11: return 'h24F;
      12: return 'h300;   13: return 'h4FF;   14: return 'h1100;  15: return 'h115F;
      16: return 'h1E00;  17: return 'h1EFF;  18: return 'h2019;  19: return 'h2E80;
      20: return 'h303E;  21: return 'h3041;  22: return 'h33FF;  23: return 'h3400;
      24: return 'h4DBF;  25: return 'h4E00;  26: return 'h9FFF;  27: return 'hA000;
      28: return 'hA4CF;  29: return 'hAC00;  30: return 'hD7AF;  31: return 'hF900;
      32: return 'hFAFF;  33: return 'hFE30;  34: return 'hFE4F;  35: return 'hFF00;
      36: return 'hFF60;  37: return 'h20000; 38: return 'h3FFFD; 39: return 'h27;
      40: return 'h2D;    41: return 'h7FF;   42: return 'hFFFF;  default: return 'h10FFFF;
    endcase
  endfunction

  function automatic logic [3:0][7:0] bytes4(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3);
    return {b3, b2, b1, b0};
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic send_window(input logic [3:0][7:0] win, input logic [CountW-1:0] cnt);
    while (!no_idle && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - 35){1'b0}}, cnt, win};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decoded_q.push_back(decode_window(win, cnt));
  endtask

  task automatic test_directed();
    send_window(bytes4(8'h41, 8'h00, 8'h00, 8'h00), 3'd1);
    send_window(bytes4(8'h00, 8'h41, 8'h41, 8'h41), 3'd4);
    send_window(bytes4(8'h41, 8'h00, 8'h00, 8'h00), 3'd0);
    send_window(bytes4(8'hF0, 8'h9F, 8'h98, 8'h80), 3'd7);
    send_window(bytes4(8'h7F, 8'hFF, 8'hFF, 8'hFF), 3'd1);
    send_window(bytes4(8'h80, 8'h80, 8'h80, 8'h80), 3'd4);
    send_window(bytes4(8'hF8, 8'h88, 8'h80, 8'h80), 3'd4);
    send_window(bytes4(8'hFF, 8'hFF, 8'hFF, 8'hFF), 3'd4);
    send_window(bytes4(8'hC2, 8'h80, 8'h00, 8'h00), 3'd2);
    send_window(bytes4(8'hC1, 8'hBF, 8'h00, 8'h00), 3'd2);
    send_window(bytes4(8'hE0, 8'h80, 8'h80, 8'h00), 3'd3);
    send_window(bytes4(8'hE0, 8'hA0, 8'h80, 8'h00), 3'd3);
    send_window(bytes4(8'hED, 8'hA0, 8'h80, 8'h00), 3'd3);
    send_window(bytes4(8'hED, 8'h9F, 8'hBF, 8'h00), 3'd3);
    send_window(bytes4(8'hEF, 8'hBF, 8'hBF, 8'h00), 3'd3);
    send_window(bytes4(8'hF0, 8'h8F, 8'hBF, 8'hBF), 3'd4);
    send_window(bytes4(8'hF4, 8'h8F, 8'hBF, 8'hBF), 3'd4);
    send_window(bytes4(8'hF4, 8'h90, 8'h80, 8'h80), 3'd4);
    send_window(bytes4(8'hE2, 8'h80, 8'h99, 8'h00), 3'd2);
    send_window(bytes4(8'hC3, 8'h28, 8'h00, 8'h00), 3'd2);
    send_window(bytes4(8'h27, 8'h00, 8'h00, 8'h00), 3'd1);
    send_window(bytes4(8'h2D, 8'h00, 8'h00, 8'h00), 3'd1);
    send_window(bytes4(8'hE2, 8'h80, 8'h99, 8'h00), 3'd3);
    send_window(bytes4(8'hE4, 8'hB8, 8'h80, 8'h00), 3'd3);
    send_window(bytes4(8'hC3, 8'hA9, 8'h00, 8'h00), 3'd6);
  endtask

  task automatic test_wellformed(input int unsigned n);
    logic [CpW-1:0]    cp;
    logic [3:0][7:0]   win;
    logic [LenW-1:0]   len;
    logic [CountW-1:0] cnt;
    int unsigned       k;
    repeat (n) begin
      case ($urandom_range(4, 0))
        0: cp = CpW'($urandom_range('h7F, 1));
        1: cp = CpW'($urandom_range('h7FF, 'h80));
        2: cp = CpW'($urandom_range('hFFFF, 'h800));
        3: cp = CpW'($urandom_range('h10FFFF, 'h10000));
        default: cp = CpW'(class_edge($urandom_range(43, 0)) + $urandom_range(2, 0) - 1);
      endcase
      len = natural_len(cp);
      win = encode_len(cp, len);
      cnt = CountW'($urandom_range(MaxCount, len));
      if ($urandom_range(9, 0) == 0) cnt = CountW'($urandom_range(7, 5));
      if ($urandom_range(99, 0) < 25) begin
        case ($urandom_range(4, 0))
          0: cnt = CountW'($urandom_range(len - 1, 0));
          1: if (len > LenOne) begin
            k = $urandom_range(len - 1, 1);
            win[k][7:6] = 2'($urandom_range(2, 0));
            if (win[k][7:6] == 2'b10) win[k][7:6] = 2'b11;
          end
          2: if (len < LenFour) begin
            win = encode_len(cp, LenW'(len + 1));
            cnt = MaxCount;
          end
          3: begin
            win = encode_len(CpW'($urandom_range(CpSurHi, CpSurLo)), LenThree);
            cnt = CountW'($urandom_range(MaxCount, LenThree));
          end
          default: begin
            win = encode_len(CpW'($urandom_range('h1FFFFF, 'h110000)), LenFour);
            cnt = MaxCount;
          end
        endcase
      end
      send_window(win, cnt);
    end
  endtask

  task automatic test_noise(input int unsigned n);
    logic [3:0][7:0]   win;
    logic [CountW-1:0] cnt;
    repeat (n) begin
      win = $urandom;
      cnt = CountW'($urandom_range(7, 0));
      if ($urandom_range(1, 0) == 1) begin
        win[1][7:6] = 2'b10;
        win[2][7:6] = 2'b10;
        win[3][7:6] = 2'b10;
      end
      send_window(win, cnt);
    end
  endtask

  task automatic test_backpressure(input int unsigned n);
    hold_req = 1'b1;
    test_wellformed(n);
  endtask

  task automatic test_steady(input int unsigned n);
    no_idle = 1'b1;
    test_wellformed(n);
    no_idle = 1'b0;
  endtask

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99, 0) >= 24);
      end
    end
  end

  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual tdata %h tuser %h",
                 $time, m_axis_tdata, m_axis_tuser);
        err_cnt++;
      end else begin
        want = decoded_q.pop_front();
        check_field("seq_length", 32'(want.len), 32'(m_axis_tdata[LenW-1:0]));
        check_field("code_point", 32'(want.cp), 32'(m_axis_tdata[LenW+CpW-1:LenW]));
        check_field("cjk_flag", 32'(want.flags.cjk), 32'(m_axis_tuser[0]));
        check_field("letter_flag", 32'(want.flags.letter), 32'(m_axis_tuser[1]));
        check_field("joiner_flag", 32'(want.flags.joiner), 32'(m_axis_tuser[2]));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_wellformed(350);
    test_noise(200);
    test_backpressure(80);
    test_steady(100);
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/udc_pkg.sv
hw/rtl/udc_lane.sv
hw/rtl/udc_merge.sv
hw/rtl/udc_class.sv
hw/rtl/utf8_decode_classify_top.sv
tb/sv/testbench.sv
